// File: hw/rtl/cpiv_pkg.sv
// Shared types and codes for the camera pixel to input value block.
package cpiv_pkg;

  // Pixel format codes.
  localparam logic [1:0] FMT_332 = 2'd0;
  localparam logic [1:0] FMT_555 = 2'd1;
  localparam logic [1:0] FMT_RGB = 2'd2;

  // Color mode codes.
  localparam logic [1:0] MODE_GRAY  = 2'd0;
  localparam logic [1:0] MODE_COLOR = 2'd1;
  localparam logic [1:0] MODE_OPP   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_FORMAT = 3'd0;
  localparam logic [2:0] REG_MODE   = 3'd1;
  localparam logic [2:0] REG_SHIFT0 = 3'd2;
  localparam logic [2:0] REG_SHIFT1 = 3'd3;
  localparam logic [2:0] REG_SHIFT2 = 3'd4;
  localparam logic [2:0] REG_MASK0  = 3'd5;
  localparam logic [2:0] REG_MASK1  = 3'd6;
  localparam logic [2:0] REG_MASK2  = 3'd7;

  // Last rotation slot before the counter wraps.
  localparam logic [1:0] SLOT_LAST = 2'd2;

  // Register file contents seen by the converter.
  typedef struct packed {
    logic [1:0]      fmt;
    logic [1:0]      mode;
    logic [2:0][3:0] shift;
    logic [2:0][7:0] mask;
  } cpiv_cfg_t;

  // One converted result item.
  typedef struct packed {
    logic        found;
    logic [23:0] value;
    logic [23:0] raw;
  } cpiv_res_t;

endpackage

// File: hw/rtl/cpiv_convert.sv
// Combinational pixel conversion: gray average, selected color and opponency.
module cpiv_convert import cpiv_pkg::*; #(
  parameter int GRAY_SHIFT = 6
) (
  input  logic [23:0] pixel,
  input  logic        found,
  input  logic [1:0]  slot,
  input  cpiv_cfg_t   cfg,
  output cpiv_res_t   res
);

  // Width of the gray sum and of the reciprocal used to divide it by three.
  localparam int SUM_W = 11 + GRAY_SHIFT;
  localparam int GW    = (SUM_W > 17) ? SUM_W : 17;
  localparam int K     = GW + 2;
  localparam logic [K-1:0] RECIP = K'((2 ** K) / 3);

  // Channel pick by index; indexes of three and up read as zero.
  function automatic logic [23:0] pick3(input logic [23:0] c0, input logic [23:0] c1,
                                        input logic [23:0] c2, input logic [7:0] idx);
    logic [23:0] sel;
    if (idx == 8'd0) begin
      sel = c0;
    end else if (idx == 8'd1) begin
      sel = c1;
    end else if (idx == 8'd2) begin
      sel = c2;
    end else begin
      sel = '0;
    end
    return sel;
  endfunction

  logic [1:0]      mode_eff;
  logic [1:0]      slot_eff;
  logic [3:0]      sh;
  logic [7:0]      mk;
  logic [7:0]      p8;
  logic [15:0]     p16;
  logic [7:0]      ch_r, ch_g, ch_b;
  logic [9:0]      rgb_sum;
  logic [GW-1:0]   gsum;
  logic [GW+K-1:0] prod;
  logic [GW-1:0]   q0;
  logic [GW-1:0]   rem;
  logic [GW-1:0]   quot;
  logic [GW:0]     quot_inc;
  logic [23:0]     gray_val;
  logic [23:0]     c0, c1, c2;
  logic [30:0]     shl16;
  logic [23:0]     val;
  logic [23:0]     raw;

  // Unused mode code falls back to gray; slot and per-slot registers.
  always_comb begin
    mode_eff = (cfg.mode == MODE_COLOR || cfg.mode == MODE_OPP) ? cfg.mode : MODE_GRAY;
    slot_eff = (slot > SLOT_LAST) ? 2'd0 : slot;
    sh       = cfg.shift[slot_eff];
    mk       = cfg.mask[slot_eff];
    p8       = pixel[7:0];
    p16      = pixel[15:0];
    ch_r     = pixel[23:16];
    ch_g     = pixel[15:8];
    ch_b     = pixel[7:0];
    rgb_sum  = 10'(ch_r) + 10'(ch_g) + 10'(ch_b);
  end

  // Gray sum per format, each channel aligned to top bit 14 before the add.
  always_comb begin
    unique case (cfg.fmt)
      FMT_332: gsum = GW'({p8[7:6], 13'd0}) + GW'({p8[5:3], 12'd0}) +
                      GW'({p8[2:0], 12'd0});
      FMT_555: gsum = GW'({p16[14:10], 10'd0}) + GW'({p16[9:5], 10'd0}) +
                      GW'({p16[4:0], 10'd0});
      default: gsum = GW'(rgb_sum) << (GRAY_SHIFT + 1);
    endcase
  end

  // Divide by three with a reciprocal that undershoots by at most one,
  // then one compare and increment, then round by half.
  always_comb begin
    prod     = (GW + K)'(gsum) * (GW + K)'(RECIP);
    q0       = GW'(prod >> K);
    rem      = gsum - (q0 + (q0 << 1));
    quot     = (rem >= GW'(3)) ? q0 + GW'(1) : q0;
    quot_inc = {1'b0, quot} + (GW + 1)'(1);
    gray_val = 24'(quot_inc >> 1);
  end

  // Opponency channels per format.
  always_comb begin
    unique case (cfg.fmt)
      FMT_332: begin
        c0 = 24'(p8[2:0]) << 11;
        c1 = 24'(p8[5:3]) << 11;
        c2 = 24'(p8[7:6]) << 12;
      end
      FMT_555: begin
        c0 = 24'(p16[14:10]) << 9;
        c1 = 24'(p16[9:5]) << 9;
        c2 = 24'(p16[4:0]) << 9;
      end
      default: begin
        c0 = 24'(ch_r);
        c1 = 24'(ch_g);
        c2 = 24'(ch_b);
      end
    endcase
  end

  // Value and echoed raw pixel per format and mode.
  always_comb begin
    shl16 = 31'(p16) << sh;
    val   = '0;
    unique case (cfg.fmt)
      FMT_332: begin
        raw = 24'(p8);
        unique case (mode_eff)
          MODE_COLOR: val = 24'(p8 & mk) << sh;
          MODE_OPP:   val = pick3(c0, c1, c2, 8'(sh)) - pick3(c0, c1, c2, mk);
          default:    val = gray_val;
        endcase
      end
      FMT_555: begin
        raw = 24'(p16);
        unique case (mode_eff)
          MODE_COLOR: val = 24'(shl16[14:10]) << 9;
          MODE_OPP:   val = pick3(c0, c1, c2, 8'(sh)) - pick3(c0, c1, c2, mk);
          default:    val = gray_val;
        endcase
      end
      default: begin
        raw = pixel;
        unique case (mode_eff)
          MODE_COLOR: val = pick3(c0, c1, c2, 8'(sh)) << GRAY_SHIFT;
          MODE_OPP:   val = (pick3(c0, c1, c2, 8'(sh)) - pick3(c0, c1, c2, mk))
                            << GRAY_SHIFT;
          default:    val = gray_val;
        endcase
      end
    endcase
  end

  // A pixel that was not found gives an all-zero item.
  assign res.found = found;
  assign res.value = found ? val : '0;
  assign res.raw   = found ? raw : '0;

endmodule

// File: hw/rtl/camera_pixel_to_input_value.sv
// Top level of the camera pixel to input value converter.
//
// Input stream: in_tdata carries one raw pixel per item, in_tuser carries the
// found flag and the rotation restart flag. Output stream: out_tdata carries
// the signed converted value and the echoed raw pixel, out_tuser the found flag.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
// must write it only while no item is in flight, and the block itself does
// not enforce it. An accepted item passes the input stage register and then
// the result register, which drives out_tvalid. There is one input stage
// register and one result register with the conversion logic between them.
// Throughput is one item per cycle while the receiver keeps out_tready high;
// the rotation slot counter is updated in the cycle an item is accepted, so
// consecutive items never wait on it. When the receiver stalls, the result
// register holds and the input stage keeps taking one more item; in_tready
// drops once both stages are full. Synchronous reset clears the configuration
// registers, the slot counter and both valid flags, but not the payload.
module camera_pixel_to_input_value import cpiv_pkg::*; #(
  parameter int GRAY_SHIFT = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input item stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] pixel
  input  logic [1:0]  in_tuser,   // [0] in_bounds, [1] restart
  // Result item stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [23:0] value, [47:24] raw
  output logic [0:0]  out_tuser,  // [0] found
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cpiv_cfg_t   cfg_r;
  logic [1:0]  slot_r, slot_nxt;
  logic [1:0]  slot_base;
  logic [1:0]  slot_use;
  logic        advance;
  logic        in_acc;
  logic        s1_move;
  logic        s1_v_r;
  logic [23:0] s1_pixel_r;
  logic        s1_found_r;
  logic [1:0]  s1_slot_r;
  logic        out_v_r;
  cpiv_res_t   out_r;
  cpiv_res_t   conv;

  // Handshake between the two stages.
  assign s1_move   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_move;
  assign in_acc    = in_tvalid && in_tready;

  // Rotation slot: restart clears before use, found items in color or opponency mode advance.
  always_comb begin
    slot_base = in_tuser[1] ? 2'd0 : slot_r;
    slot_use  = (slot_base > SLOT_LAST) ? 2'd0 : slot_base;
    advance   = in_tuser[0] && (cfg_r.mode == MODE_COLOR || cfg_r.mode == MODE_OPP);
    if (!in_acc) begin
      slot_nxt = slot_r;
    end else if (advance) begin
      slot_nxt = (slot_use == SLOT_LAST) ? 2'd0 : slot_use + 2'd1;
    end else begin
      slot_nxt = slot_base;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT: cfg_r.fmt      <= cfg_data[1:0];
        REG_MODE:   cfg_r.mode     <= cfg_data[1:0];
        REG_SHIFT0: cfg_r.shift[0] <= cfg_data[3:0];
        REG_SHIFT1: cfg_r.shift[1] <= cfg_data[3:0];
        REG_SHIFT2: cfg_r.shift[2] <= cfg_data[3:0];
        REG_MASK0:  cfg_r.mask[0]  <= cfg_data;
        REG_MASK1:  cfg_r.mask[1]  <= cfg_data;
        REG_MASK2:  cfg_r.mask[2]  <= cfg_data;
        default:    cfg_r          <= cfg_r;
      endcase
    end
  end

  // Slot counter and stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (!out_v_r || out_tready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r <= in_tdata;
      s1_found_r <= in_tuser[0];
      s1_slot_r  <= slot_use;
    end
  end

  cpiv_convert #(
    .GRAY_SHIFT(GRAY_SHIFT)
  ) u_convert (
    .pixel (s1_pixel_r),
    .found (s1_found_r),
    .slot  (s1_slot_r),
    .cfg   (cfg_r),
    .res   (conv)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r <= conv;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = {out_r.raw, out_r.value};
  assign out_tuser[0] = out_r.found;

`ifndef SYNTHESIS
  // The rotation counter only ever holds slots zero to two.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_LAST)
    else $error("slot counter out of range");

  // A found color item without restart steps the slot by one, wrapping.
  a_slot_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] && !in_tuser[1] && cfg_r.mode == MODE_COLOR) |=>
    (slot_r == (($past(slot_r) == SLOT_LAST) ? 2'd0 : $past(slot_r) + 2'd1)))
    else $error("slot counter did not advance");

  // A full input stage is never dropped while the result is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_tready) |=> (s1_v_r && $stable(s1_pixel_r)))
    else $error("input stage lost an item");

  // A not-found item leaves value and raw at zero.
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.found) |-> (out_r.value == '0 && out_r.raw == '0))
    else $error("not-found item carries data");
`endif

endmodule

// File: verif/tb.sv
// Self-checking testbench for the camera pixel to input value converter.
`timescale 1ns / 1ps

module tb;
  import cpiv_pkg::*;

  localparam int GRAY_SHIFT     = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 13;
  localparam int PHASE_ITEMS    = 150;

  // One input item as the sender sees it.
  typedef struct packed {
    logic [23:0] pixel;
    logic        in_bounds;
    logic        restart;
  } pix_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // [23:0] pixel
  logic [1:0]  in_tuser = '0;    // [0] in_bounds, [1] restart
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // [23:0] value, [47:24] raw
  logic [0:0]  out_tuser;        // [0] found
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // Items waiting to be sent and results waiting to arrive.
  pix_item_t pixel_q[$];
  cpiv_res_t result_q[$];

  // Shadow copy of the register file and the rotation slot.
  logic [1:0] m_fmt = FMT_332;
  logic [1:0] m_mode = MODE_GRAY;
  logic [3:0] m_shift[3] = '{default: '0};
  logic [7:0] m_mask[3] = '{default: '0};
  logic [1:0] slot_m = '0;

  logic idle_on = 1'b1;
  logic send_hold = 1'b0;
  int   err_cnt = 0;
  int   idle_cycles = 0;

  camera_pixel_to_input_value #(
    .GRAY_SHIFT(GRAY_SHIFT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Channel lookup where an index past blue reads as zero.
  function automatic logic [31:0] pick_chan(input logic [31:0] c0, input logic [31:0] c1,
                                            input logic [31:0] c2, input logic [7:0] idx);
    case (idx)
      8'd0:    return c0;
      8'd1:    return c1;
      8'd2:    return c2;
      default: return 32'd0;
    endcase
  endfunction

  // Work out the result of one accepted pixel and queue it.
  task automatic convert_pixel(input pix_item_t it);
    logic [1:0]  s;
    logic [3:0]  sh;
    logic [7:0]  mk;
    logic [31:0] p, acc, val, c0, c1, c2;
    cpiv_res_t   r;
    r = '0;
    if (it.restart) slot_m = '0;
    if (it.in_bounds) begin
      s  = (slot_m > SLOT_LAST) ? 2'd0 : slot_m;
      sh = m_shift[s];
      mk = m_mask[s];
      if (m_mode == MODE_COLOR || m_mode == MODE_OPP) begin
        slot_m = (s >= SLOT_LAST) ? 2'd0 : s + 2'd1;
      end
      if (m_fmt == FMT_332) begin
        p = {24'd0, it.pixel[7:0]};
        // Red keeps all three bits at 12-14 in the gray sum.
        acc = ((p << 7) & 32'h6000) + ((p << 9) & 32'h7000) + ((p << 12) & 32'h7000);
        c0  = (p & 32'h07) << 11;
        c1  = (p & 32'h38) << 8;
        c2  = (p & 32'hC0) << 6;
        if (m_mode == MODE_COLOR) val = (p & {24'd0, mk}) << sh;
        else if (m_mode == MODE_OPP) val = pick_chan(c0, c1, c2, {4'd0, sh}) -
                                           pick_chan(c0, c1, c2, mk);
        else val = (acc / 3 + 1) >> 1;
      end else if (m_fmt == FMT_555) begin
        p   = {16'd0, it.pixel[15:0]};
        acc = (p & 32'h7C00) + ((p << 5) & 32'h7C00) + ((p << 10) & 32'h7C00);
        c0  = (p >> 1) & 32'h3E00;
        c1  = (p << 4) & 32'h3E00;
        c2  = (p << 9) & 32'h3E00;
        if (m_mode == MODE_COLOR) val = ((p << sh) & 32'h7C00) >> 1;
        else if (m_mode == MODE_OPP) val = pick_chan(c0, c1, c2, {4'd0, sh}) -
                                           pick_chan(c0, c1, c2, mk);
        else val = (acc / 3 + 1) >> 1;
      end else begin
        // Format code 3 behaves as 24-bit RGB.
        p   = {8'd0, it.pixel};
        c0  = {24'd0, it.pixel[23:16]};
        c1  = {24'd0, it.pixel[15:8]};
        c2  = {24'd0, it.pixel[7:0]};
        acc = (c0 + c1 + c2) << (GRAY_SHIFT + 1);
        if (m_mode == MODE_COLOR) val = pick_chan(c0, c1, c2, {4'd0, sh}) << GRAY_SHIFT;
        else if (m_mode == MODE_OPP) val = (pick_chan(c0, c1, c2, {4'd0, sh}) -
                                            pick_chan(c0, c1, c2, mk)) << GRAY_SHIFT;
        else val = (acc / 3 + 1) >> 1;
      end
      r.found = 1'b1;
      r.value = val[23:0];
      r.raw   = p[23:0];
    end
    result_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Sender: holds an offered item until taken, then offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        convert_pixel(pixel_q[0]);
        void'(pixel_q.pop_front());
      end
      if (pixel_q.size() != 0 && !send_hold && !(idle_on && $urandom_range(99) < 26)) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pixel_q[0].pixel;
        in_tuser  <= {pixel_q[0].restart, pixel_q[0].in_bounds};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure and a field-by-field check of each item.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !(idle_on && $urandom_range(99) < 26);
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result item", out_tdata[23:0], 24'd0);
        end else begin
          if (out_tuser[0] !== result_q[0].found)
            report_mismatch("found", {23'd0, out_tuser[0]}, {23'd0, result_q[0].found});
          if (out_tdata[23:0] !== result_q[0].value)
            report_mismatch("value", out_tdata[23:0], result_q[0].value);
          if (out_tdata[47:24] !== result_q[0].raw)
            report_mismatch("raw", out_tdata[47:24], result_q[0].raw);
          void'(result_q.pop_front());
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_FORMAT: m_fmt = data[1:0];
      REG_MODE:   m_mode = data[1:0];
      REG_SHIFT0: m_shift[0] = data[3:0];
      REG_SHIFT1: m_shift[1] = data[3:0];
      REG_SHIFT2: m_shift[2] = data[3:0];
      REG_MASK0:  m_mask[0] = data;
      REG_MASK1:  m_mask[1] = data;
      REG_MASK2:  m_mask[2] = data;
      default: ;
    endcase
  endtask

  // Write all eight registers; only called with nothing in flight.
  task automatic apply_config(input logic [1:0] fmt, input logic [1:0] mode,
                              input logic [3:0] s0, input logic [3:0] s1, input logic [3:0] s2,
                              input logic [7:0] k0, input logic [7:0] k1, input logic [7:0] k2);
    write_reg(REG_FORMAT, {6'd0, fmt});
    write_reg(REG_MODE, {6'd0, mode});
    write_reg(REG_SHIFT0, {4'd0, s0});
    write_reg(REG_SHIFT1, {4'd0, s1});
    write_reg(REG_SHIFT2, {4'd0, s2});
    write_reg(REG_MASK0, k0);
    write_reg(REG_MASK1, k1);
    write_reg(REG_MASK2, k2);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_item(input logic [23:0] pixel, input logic inb, input logic rs);
    pix_item_t it;
    it.pixel     = pixel;
    it.in_bounds = inb;
    it.restart   = rs;
    pixel_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_tvalid || result_q.size() != 0) @(negedge clk);
  endtask

  // Mostly small channel indices so that opponency picks real channels.
  function automatic logic [3:0] rand_shift();
    return ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
  endfunction

  function automatic logic [7:0] rand_mask();
    return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
  endfunction

  initial begin
    int          ph, n;
    logic [23:0] pix;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: 3-3-2 gray, red in full, and a not-found item.
    queue_item(24'h000000, 1'b1, 1'b0);
    queue_item(24'hFFFFFF, 1'b1, 1'b0);
    queue_item(24'h000007, 1'b1, 1'b0);
    queue_item(24'h0000C0, 1'b1, 1'b0);
    queue_item(24'hFFFFFF, 1'b0, 1'b1);
    wait_drained();

    // 5-5-5 selected color with shifts of 15, 5 and 0, masks ignored.
    apply_config(FMT_555, MODE_COLOR, 4'd15, 4'd5, 4'd0, 8'hFF, 8'h00, 8'hFF);
    queue_item(24'h00FFFF, 1'b1, 1'b0);
    queue_item(24'h7F7FFF, 1'b1, 1'b0);
    queue_item(24'h001F00, 1'b1, 1'b0);
    queue_item(24'h0003E0, 1'b1, 1'b1);
    wait_drained();

    // RGB opponency with indices past blue and not-found items between.
    apply_config(FMT_RGB, MODE_OPP, 4'd0, 4'd3, 4'd15, 8'd2, 8'd1, 8'hFF);
    queue_item(24'hFF0000, 1'b1, 1'b1);
    queue_item(24'h0000FF, 1'b1, 1'b0);
    queue_item(24'hFFFFFF, 1'b0, 1'b0);
    queue_item(24'hFFFFFF, 1'b1, 1'b0);
    queue_item(24'h00FF00, 1'b1, 1'b0);
    queue_item(24'h0000FF, 1'b0, 1'b1);
    queue_item(24'h0000FF, 1'b1, 1'b0);
    wait_drained();

    // Unused format and mode codes.
    apply_config(2'd3, 2'd3, 4'd1, 4'd2, 4'd0, 8'd1, 8'd0, 8'd2);
    queue_item(24'hFFFFFF, 1'b1, 1'b0);
    queue_item(24'h123456, 1'b1, 1'b0);
    queue_item(24'h000000, 1'b1, 1'b1);
    wait_drained();

    // 3-3-2 opponency on the extremes.
    apply_config(FMT_332, MODE_OPP, 4'd2, 4'd1, 4'd0, 8'd0, 8'd2, 8'd1);
    queue_item(24'h0000FF, 1'b1, 1'b0);
    queue_item(24'h000007, 1'b1, 1'b0);
    queue_item(24'h0000C0, 1'b1, 1'b0);
    wait_drained();

    // Random phases, each with its own register settings.
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)
        apply_config(FMT_RGB, MODE_OPP, 4'd15, 4'd15, 4'd15, 8'hFF, 8'hFF, 8'hFF);
      else if (ph == 1)
        apply_config(FMT_332, MODE_COLOR, 4'd0, 4'd0, 4'd0, 8'h00, 8'h00, 8'h00);
      else if (ph == 2)
        apply_config(FMT_332, MODE_COLOR, 4'd15, 4'd15, 4'd15, 8'hFF, 8'hFF, 8'hFF);
      else
        apply_config(2'($urandom_range(3)), 2'($urandom_range(3)), rand_shift(),
                     rand_shift(), rand_shift(), rand_mask(), rand_mask(), rand_mask());
      // One phase runs with both sides always ready.
      idle_on = (ph != 6);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pix = 24'($urandom);
        if ($urandom_range(19) == 0) pix = $urandom_range(1) ? 24'hFFFFFF : 24'h000000;
        queue_item(pix, $urandom_range(99) < 85, $urandom_range(15) == 0);
      end
      // Midway through one phase the sender stops until the block has drained.
      if (ph == 4) begin
        while (pixel_q.size() > PHASE_ITEMS / 2) @(negedge clk);
        send_hold = 1'b1;
        while (in_tvalid || result_q.size() != 0) @(negedge clk);
        send_hold = 1'b0;
      end
      wait_drained();
    end

    idle_on = 1'b1;
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
